[sv/gtm_pkg.sv]
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared item codes, widths and lane control type for the 4x4 GEMM tile.
// ----------------------------------------------------------------------------
package gtm_pkg;

  localparam int TILE       = 4;
  localparam int FIELD_W    = 32;
  localparam int KIND_W     = 2;
  localparam int ROW_W      = 2;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

  typedef logic signed [FIELD_W-1:0] field_t;

  typedef struct packed {
    logic              load;
    logic              advance;
    logic [KIND_W-1:0] kind;
  } gtm_ctl_t;

endpackage

[sv/gtm_cmd_if.sv]
// ----------------------------------------------------------------------------
// gtm_cmd_if
// Command channel: clear, accumulate step or row readout.
// ----------------------------------------------------------------------------
interface gtm_cmd_if import gtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ROW_W-1:0]  row;
  field_t            op_a0;
  field_t            op_a1;
  field_t            op_a2;
  field_t            op_a3;
  field_t            op_b0;
  field_t            op_b1;
  field_t            op_b2;
  field_t            op_b3;

  modport source (output valid, kind, row, op_a0, op_a1, op_a2, op_a3,
                  op_b0, op_b1, op_b2, op_b3, input ready);
  modport sink (input valid, kind, row, op_a0, op_a1, op_a2, op_a3,
                op_b0, op_b1, op_b2, op_b3, output ready);
endinterface

[sv/gtm_res_if.sv]
// ----------------------------------------------------------------------------
// gtm_res_if
// Result channel: one row of old C plus accumulators.
// ----------------------------------------------------------------------------
interface gtm_res_if import gtm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  field_t           sum0;
  field_t           sum1;
  field_t           sum2;
  field_t           sum3;

  modport source (output valid, out_row, sum0, sum1, sum2, sum3, input ready);
  modport sink (input valid, out_row, sum0, sum1, sum2, sum3, output ready);
endinterface

[sv/gtm_lane.sv]
// ----------------------------------------------------------------------------
// gtm_lane
// One multiply-accumulate cell: registered scaled product, then accumulator.
// ----------------------------------------------------------------------------
module gtm_lane import gtm_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gtm_ctl_t              ctl,
  input  field_t                a,
  input  field_t                b,
  output logic [DATA_WIDTH-1:0] acc
);

  logic signed [2*FIELD_W-1:0] full;
  logic signed [2*FIELD_W-1:0] scaled;
  logic [DATA_WIDTH-1:0]       prod;

  assign full   = a * b;
  assign scaled = full >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= scaled[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.advance) begin
      case (ctl.kind)
        KIND_CLEAR: acc <= '0;
        KIND_STEP:  acc <= acc + prod;
        default:    acc <= acc;
      endcase
    end
  end

endmodule

[sv/gtm_merge.sv]
// ----------------------------------------------------------------------------
// gtm_merge
// Row select over the lanes, add old C, hold the result for the sink.
// ----------------------------------------------------------------------------
module gtm_merge import gtm_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [ROW_W-1:0]      row,
  input  field_t                old_c [TILE],
  input  logic [DATA_WIDTH-1:0] acc [TILE*TILE],
  gtm_res_if.source             res
);

  logic [DATA_WIDTH-1:0] total [TILE];
  field_t                sum_next [TILE];

  always_comb begin
    for (int c = 0; c < TILE; c++) begin
      total[c]    = DATA_WIDTH'(old_c[c]) + acc[{row, 2'(c)}];
      sum_next[c] = FIELD_W'(total[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.out_row <= row;
      res.sum0    <= sum_next[0];
      res.sum1    <= sum_next[1];
      res.sum2    <= sum_next[2];
      res.sum3    <= sum_next[3];
    end
  end

endmodule

[sv/gemm_tile_4x4_mac.sv]
// ----------------------------------------------------------------------------
// gemm_tile_4x4_mac
// 4x4 register-blocked matrix-multiply tile with sixteen parallel MAC lanes.
//
//   channel  role    payload
//   cmd      sink    kind, row, op_a0..op_a3, op_b0..op_b3
//   res      source  out_row, sum0..sum3
//
// One item per cycle unless a readout stalls; a step passes the 32x32
// multipliers into the product registers, then the accumulators. A readout
// passes the operand stage, then the result register. Reset clears the sixteen
// accumulators. Clear and step items keep flowing while a result waits; a
// second readout stalls in the operand stage until the result is taken.
// ----------------------------------------------------------------------------
module gemm_tile_4x4_mac import gtm_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  gtm_cmd_if.sink    cmd,
  gtm_res_if.source  res
);

  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [ROW_W-1:0]  s1_row;
  field_t            s1_old [TILE];
  logic              s1_go;
  logic              take;
  gtm_ctl_t          ctl;
  field_t            op_a [TILE];
  field_t            op_b [TILE];
  logic [DATA_WIDTH-1:0] acc [TILE*TILE];

  assign op_a[0] = cmd.op_a0;
  assign op_a[1] = cmd.op_a1;
  assign op_a[2] = cmd.op_a2;
  assign op_a[3] = cmd.op_a3;
  assign op_b[0] = cmd.op_b0;
  assign op_b[1] = cmd.op_b1;
  assign op_b[2] = cmd.op_b2;
  assign op_b[3] = cmd.op_b3;

  assign s1_go     = s1_valid && (s1_kind != KIND_READ || !res.valid || res.ready);
  assign cmd.ready = !s1_valid || s1_go;
  assign take      = cmd.valid && cmd.ready;

  assign ctl.load    = take;
  assign ctl.advance = s1_go;
  assign ctl.kind    = s1_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind <= cmd.kind;
      s1_row  <= cmd.row;
      s1_old  <= op_a;
    end
  end

  for (genvar r = 0; r < TILE; r++) begin : g_row
    for (genvar c = 0; c < TILE; c++) begin : g_col
      gtm_lane #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
        .clk (clk),
        .rst (rst),
        .ctl (ctl),
        .a   (op_a[r]),
        .b   (op_b[c]),
        .acc (acc[r*TILE+c])
      );
    end
  end

  gtm_merge #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .fire  (s1_go && s1_kind == KIND_READ),
    .row   (s1_row),
    .old_c (s1_old),
    .acc   (acc),
    .res   (res)
  );

`ifndef NO_ASSERTIONS
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_kind == KIND_CLEAR |=> acc[0] == '0 && acc[TILE*TILE-1] == '0)
    else $error("clear left an accumulator nonzero");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> s1_valid && s1_kind == KIND_READ && res.valid)
    else $error("input stalled without a pending readout");

  a_read_row: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_kind == KIND_READ |=> res.valid && res.out_row == $past(s1_row))
    else $error("readout did not reach the result register");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    res.valid && !$past(res.valid) |-> $past(s1_go && s1_kind == KIND_READ))
    else $error("result without a readout");

  a_nop_keeps: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_kind == KIND_NOP |=> $stable(acc[0]) && $stable(acc[TILE*TILE-1]))
    else $error("unused kind changed the accumulators");
`endif

endmodule

[dv/tb_gemm_tile_4x4_mac.sv]
// ----------------------------------------------------------------------------
// tb_gemm_tile_4x4_mac
// Self-checking bench for the 4x4 GEMM tile. A queue-fed driver sends clear,
// step, readout and unused items. A local tile model predicts every readout
// row, and a monitor compares each result transfer field by field. Both
// channels idle at random. The receiver holds off once for a long stretch,
// and the sender drains between phases.
// ----------------------------------------------------------------------------
module tb_gemm_tile_4x4_mac import gtm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 8;
  localparam int IDLE_PCT    = 13;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 10;

  localparam field_t F_MAX = 32'sh7fffffff;
  localparam field_t F_MIN = 32'sh80000000;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [ROW_W-1:0]      row;
    field_t [TILE-1:0]     a;
    field_t [TILE-1:0]     b;
  } cmd_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    field_t [TILE-1:0] sum;
  } row_sum_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gtm_cmd_if cmd_ch ();
  gtm_res_if res_ch ();

  gemm_tile_4x4_mac #(
    .DATA_WIDTH(DATA_W),
    .FRAC_BITS (FRAC_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  cmd_item_t         cmd_q[$];
  row_sum_t          row_sum_q[$];
  cmd_item_t         cur_cmd;
  logic [DATA_W-1:0] tile_acc[TILE*TILE];
  int                n_cmd_done = 0;
  int                n_res_done = 0;
  int                n_fail     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.kind  = KIND_NOP;
    cmd_ch.row   = '0;
    cmd_ch.op_a0 = '0;
    cmd_ch.op_a1 = '0;
    cmd_ch.op_a2 = '0;
    cmd_ch.op_a3 = '0;
    cmd_ch.op_b0 = '0;
    cmd_ch.op_b1 = '0;
    cmd_ch.op_b2 = '0;
    cmd_ch.op_b3 = '0;
    res_ch.ready = 1'b0;
    foreach (tile_acc[i]) tile_acc[i] = '0;
  end

  function automatic logic [DATA_W-1:0] scaled_mul(field_t x, field_t y);
    longint p;
    p = longint'(x) * longint'(y);
    p = p >>> FRAC_W;
    return p[DATA_W-1:0];
  endfunction

  task automatic tile_apply(cmd_item_t it);
    row_sum_t          exp_row;
    logic [DATA_W-1:0] s;
    case (it.kind)
      KIND_CLEAR: begin
        foreach (tile_acc[i]) tile_acc[i] = '0;
      end
      KIND_STEP: begin
        for (int r = 0; r < TILE; r++) begin
          for (int c = 0; c < TILE; c++) begin
            tile_acc[r*TILE+c] = tile_acc[r*TILE+c] + scaled_mul(it.a[r], it.b[c]);
          end
        end
      end
      KIND_READ: begin
        exp_row.row = it.row;
        for (int c = 0; c < TILE; c++) begin
          s = DATA_W'(longint'(it.a[c])) + tile_acc[it.row*TILE+c];
          exp_row.sum[c] = FIELD_W'(s);
        end
        row_sum_q.push_back(exp_row);
      end
      default: begin
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    logic xfer;
    logic quiet;
    xfer  = cmd_ch.valid && cmd_ch.ready;
    quiet = (n_cmd_done >= 300) && (n_cmd_done < 600);
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (xfer) begin
        tile_apply(cur_cmd);
        n_cmd_done++;
      end
      if (!cmd_ch.valid || xfer) begin
        if (cmd_q.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          cur_cmd = cmd_q.pop_front();
          cmd_ch.kind  <= cur_cmd.kind;
          cmd_ch.row   <= cur_cmd.row;
          cmd_ch.op_a0 <= cur_cmd.a[0];
          cmd_ch.op_a1 <= cur_cmd.a[1];
          cmd_ch.op_a2 <= cur_cmd.a[2];
          cmd_ch.op_a3 <= cur_cmd.a[3];
          cmd_ch.op_b0 <= cur_cmd.b[0];
          cmd_ch.op_b1 <= cur_cmd.b[1];
          cmd_ch.op_b2 <= cur_cmd.b[2];
          cmd_ch.op_b3 <= cur_cmd.b[3];
          cmd_ch.valid <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with one long hold-off
  always @(posedge clk) begin
    int   hold_left;
    logic hold_done;
    logic quiet;
    quiet = (n_res_done >= 100) && (n_res_done < 250);
    if (rst) begin
      hold_left = 0;
      hold_done = 1'b0;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (!hold_done && n_cmd_done >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor
  always @(posedge clk) begin
    row_sum_t exp_row;
    field_t   got[TILE];
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_res_done++;
      got = '{res_ch.sum0, res_ch.sum1, res_ch.sum2, res_ch.sum3};
      if (row_sum_q.size() == 0) begin
        $error("unexpected result transfer: out_row %0d", res_ch.out_row);
        n_fail++;
      end else begin
        exp_row = row_sum_q.pop_front();
        if (res_ch.out_row !== exp_row.row) begin
          $error("out_row: expected %0d, got %0d", exp_row.row, res_ch.out_row);
          n_fail++;
        end
        for (int c = 0; c < TILE; c++) begin
          if (got[c] !== exp_row.sum[c]) begin
            $error("sum%0d: expected %0d, got %0d", c, exp_row.sum[c], got[c]);
            n_fail++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    int stall;
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall = 0;
    end else begin
      stall++;
      if (stall >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic cmd_item_t mk(logic [KIND_W-1:0] k, logic [ROW_W-1:0] r,
                                   field_t a0, field_t a1, field_t a2, field_t a3,
                                   field_t b0, field_t b1, field_t b2, field_t b3);
    cmd_item_t it;
    it.kind = k;
    it.row  = r;
    it.a    = {a3, a2, a1, a0};
    it.b    = {b3, b2, b1, b0};
    return it;
  endfunction

  function automatic field_t pick_operand();
    case ($urandom_range(3))
      0: return field_t'($urandom);
      1: return field_t'($urandom_range(2048)) - 1024;
      2: begin
        case ($urandom_range(4))
          0: return F_MAX;
          1: return F_MIN;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
      default: return field_t'($urandom_range(1 << 21)) - (1 << 20);
    endcase
  endfunction

  function automatic cmd_item_t random_item(logic [KIND_W-1:0] k);
    return mk(k, ROW_W'($urandom_range(TILE - 1)),
              pick_operand(), pick_operand(), pick_operand(), pick_operand(),
              pick_operand(), pick_operand(), pick_operand(), pick_operand());
  endfunction

  task automatic gen_random(int n_items);
    int        n;
    int        n_steps;
    int        n_reads;
    cmd_item_t it;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(9) < 7) begin
          cmd_q.push_back(random_item(KIND_CLEAR));
          n++;
        end
        n_steps = $urandom_range(1, 6);
        repeat (n_steps) cmd_q.push_back(random_item(KIND_STEP));
        n_reads = $urandom_range(1, 4);
        repeat (n_reads) cmd_q.push_back(random_item(KIND_READ));
        n += n_steps + n_reads;
      end else begin
        it = mk(KIND_W'($urandom_range(KIND_NOP)), ROW_W'($urandom),
                field_t'($urandom), field_t'($urandom), field_t'($urandom),
                field_t'($urandom), field_t'($urandom), field_t'($urandom),
                field_t'($urandom), field_t'($urandom));
        cmd_q.push_back(it);
        if (it.kind != KIND_NOP) n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || cmd_ch.valid || row_sum_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    cmd_q.push_back(mk(KIND_READ, 0, 0, 0, 0, 0, F_MAX, F_MIN, -1, 0));
    cmd_q.push_back(mk(KIND_STEP, 3, F_MAX, F_MIN, -1, 0, F_MAX, F_MIN, -1, 1));
    cmd_q.push_back(mk(KIND_STEP, 2, -1, 1, 255, -255, 255, -255, 1, 256));
    cmd_q.push_back(random_item(KIND_NOP));
    cmd_q.push_back(mk(KIND_READ, 0, F_MAX, F_MIN, -1, 0, -1, -1, -1, -1));
    cmd_q.push_back(mk(KIND_READ, 1, F_MIN, F_MAX, 0, -1, F_MAX, 0, F_MIN, 1));
    cmd_q.push_back(mk(KIND_READ, 2, 0, -1, F_MAX, F_MIN, 0, 0, 0, 0));
    cmd_q.push_back(mk(KIND_READ, 3, -1, 0, F_MIN, F_MAX, F_MIN, F_MIN, F_MIN, F_MIN));
    cmd_q.push_back(mk(KIND_NOP, 2, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX));
    cmd_q.push_back(mk(KIND_READ, 1, 7, 7, 7, 7, 0, 0, 0, 0));
    cmd_q.push_back(mk(KIND_CLEAR, 3, F_MIN, -1, F_MAX, 5, -1, -1, -1, -1));
    cmd_q.push_back(mk(KIND_READ, 2, F_MAX, F_MAX, F_MIN, F_MIN, -1, -1, -1, -1));
    repeat (4) begin
      cmd_q.push_back(mk(KIND_STEP, 1, F_MAX, F_MAX, F_MAX, F_MAX,
                         F_MAX, F_MAX, F_MAX, F_MAX));
    end
    cmd_q.push_back(mk(KIND_READ, 1, F_MAX, F_MAX, F_MAX, F_MAX, 0, 0, 0, 0));
    cmd_q.push_back(mk(KIND_STEP, 0, F_MIN, F_MIN, F_MIN, F_MIN,
                       F_MIN, F_MIN, F_MIN, F_MIN));
    cmd_q.push_back(mk(KIND_READ, 3, F_MIN, F_MIN, F_MIN, F_MIN, 0, 0, 0, 0));
    cmd_q.push_back(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(KIND_READ, 0, 1, -1, 0, F_MAX, 0, 0, 0, 0));
    wait_drained();

    gen_random(700);
    wait_drained();

    gen_random(700);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (n_fail == 0 && row_sum_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
